// ===== rtl/core/lljd_pkg.sv =====
// shared widths and constants of the least-loaded job dispatch unit
`default_nettype none

package lljd_pkg;

  localparam int DUR_W  = 16;
  localparam int LOAD_W = 32;
  localparam int JOB_W  = 16;
  localparam int SRV_W  = 4;
  localparam int ACT_W  = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register word index taken from paddr[2]
  localparam logic REG_ACTIVE = 1'b0;

  localparam logic [ACT_W-1:0]  ACTIVE_RESET = 5'd16;
  localparam logic [LOAD_W-1:0] LOAD_MAX     = '1;

  typedef logic [LOAD_W-1:0] load_t;

endpackage

`default_nettype wire

// ===== rtl/core/least_loaded_job_dispatch_unit.sv =====
// least-loaded job dispatch unit: load memory, sequential scan and update
// one job at a time: in_stall is high from acceptance until the write-back
// (idle/accept, n reads of the load memory on its single read port, n =
// effective active server count, a drain step for the last compare, then
// the write-back, which registers the result word and waits on out_stall)
// reset: rst_n synchronous active low; load valid bits cleared at once (loads
// read as zero), job counter zero, active_servers = 16; no clearing pass
`default_nettype none

module least_loaded_job_dispatch_unit import lljd_pkg::*; #(
  parameter int SERVERS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [DUR_W-1:0]  in_job_duration,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [SRV_W-1:0]  out_chosen_server,
  output      logic [JOB_W-1:0]  out_job_number,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output      logic [DATA_W-1:0] cfg_prdata,
  output      logic              cfg_pready
);

  localparam int IDX_W = $clog2(SERVERS);
  localparam int CNT_W = $clog2(SERVERS + 1);
  localparam int AW    = (CNT_W > ACT_W) ? CNT_W : ACT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_LAST   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [ACT_W-1:0]   active_r;
  logic [SERVERS-1:0] valid_r;
  logic [JOB_W-1:0]   job_cnt_r;
  logic [DUR_W-1:0]   dur_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_vld_r;
  logic               rd_vld_r;
  load_t              rd_data_r;
  load_t              best_load_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               out_valid_r;
  logic [SRV_W-1:0]   out_srv_r;
  logic [JOB_W-1:0]   out_job_r;

  load_t              mem [SERVERS];

  logic [AW-1:0]      act_ext;
  logic [AW-1:0]      n_eff;
  logic [IDX_W-1:0]   last_idx;
  load_t              cur_load;
  logic               take;
  logic [LOAD_W:0]    sum;
  load_t              sum_sat;
  logic               upd_go;
  logic               in_acc;
  logic               cfg_wr;

  // effective server count, clamped to 1..SERVERS
  always_comb begin
    act_ext = AW'(active_r);
    if (act_ext == '0) begin
      n_eff = AW'(1);
    end else if (act_ext > AW'(SERVERS)) begin
      n_eff = AW'(SERVERS);
    end else begin
      n_eff = act_ext;
    end
    last_idx = IDX_W'(n_eff - AW'(1));
  end

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign upd_go   = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);

  // never-written entries read as zero
  assign cur_load = rd_vld_r ? rd_data_r : '0;
  assign take     = (cmp_idx_r == '0) || (cur_load < best_load_r);

  assign sum     = {1'b0, best_load_r} + (LOAD_W + 1)'(dur_r);
  assign sum_sat = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE) ? DATA_W'(active_r) : '0;

  assign out_valid         = out_valid_r;
  assign out_chosen_server = out_srv_r;
  assign out_job_number    = out_job_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == last_idx) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // load memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (upd_go) begin
      mem[best_idx_r] <= sum_sat;
    end
    rd_data_r <= mem[idx_r];
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    rd_vld_r  <= valid_r[idx_r];
    cmp_idx_r <= idx_r;
    if (in_acc) begin
      dur_r <= in_job_duration;
    end
    // index stops at the last active server so it never leaves the memory
    if (in_acc) begin
      idx_r <= '0;
    end else if (state_r == ST_SCAN && idx_r != last_idx) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmp_vld_r && take) begin
      best_load_r <= cur_load;
      best_idx_r  <= cmp_idx_r;
    end
    if (upd_go) begin
      out_srv_r <= SRV_W'(best_idx_r);
      out_job_r <= job_cnt_r + JOB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= ACTIVE_RESET;
      valid_r     <= '0;
      job_cnt_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SCAN);
      if (cfg_wr && cfg_paddr[2] == REG_ACTIVE) begin
        active_r <= cfg_pwdata[ACT_W-1:0];
      end
      if (upd_go) begin
        valid_r[best_idx_r] <= 1'b1;
        job_cnt_r           <= job_cnt_r + JOB_W'(1);
        out_valid_r         <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN && idx_r == '0))
    else $error("accepted job did not start a scan at server zero");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= last_idx))
    else $error("scan index ran past the active servers");

  a_drained_before_write: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |-> !cmp_vld_r)
    else $error("load write-back while a compare is still pending");

  a_result_number: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> (out_valid_r && out_job_r == job_cnt_r))
    else $error("result word job number differs from job counter");

endmodule

`default_nettype wire
